@@ rtl/sevuf_pkg.sv @@
// shared types, constants and codes of the species evidence filter
`default_nettype none

package sevuf_pkg;

    // field widths fixed by the item format
    localparam int SP_W      = 10;
    localparam int SCORE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int OUT_CNT_W = 32;
    localparam int CFG_IDX_W = 2;

    // default sizing
    localparam int DEF_SPECIES_SLOTS = 1024;
    localparam int DEF_COUNT_BITS    = 32;

    // opcodes
    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_DECIDE     = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STRONG_SCORE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STRONG_READS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_UNIQUE_READS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIE_RATIO        = 2'd3;

    // configuration reset values (q1.15 where a score or ratio)
    localparam logic [CFG_W-1:0] RST_MIN_STRONG_SCORE = 16'd22938;
    localparam logic [CFG_W-1:0] RST_MIN_STRONG_READS = 16'd3;
    localparam logic [CFG_W-1:0] RST_MIN_UNIQUE_READS = 16'd2;
    localparam logic [CFG_W-1:0] RST_TIE_RATIO        = 16'd32440;

    typedef struct packed {
        logic               opcode;
        logic [SP_W-1:0]    species_index;
        logic [SCORE_W-1:0] hit_score;
        logic               first_of_read;
        logic               last_of_read;
    } t_in_item;

    typedef struct packed {
        logic                 present;
        logic                 keep;
        logic                 pass_evidence;
        logic                 pass_unique;
        logic [OUT_CNT_W-1:0] occurrence_count;
        logic [OUT_CNT_W-1:0] strong_count;
        logic [OUT_CNT_W-1:0] unique_count;
        logic [SCORE_W-1:0]   best_score;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic latch_in;
        logic rd_pend;
        logic rd_main;
        logic wr_credit;
        logic wr_main;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_decide;
        logic first;
        logic pending;
        logic out_free;
        logic clr_done;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/sevuf_in_if.sv @@
// input item channel
`default_nettype none

interface sevuf_in_if;
    import sevuf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/sevuf_out_if.sv @@
// result item channel
`default_nettype none

interface sevuf_out_if;
    import sevuf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/sevuf_cfg_if.sv @@
// configuration write channel
`default_nettype none

interface sevuf_cfg_if;
    import sevuf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/sevuf_datapath.sv @@
// evidence table memory, pending top, config registers and result register
`default_nettype none

module sevuf_datapath #(
    parameter int SPECIES_SLOTS = sevuf_pkg::DEF_SPECIES_SLOTS,
    parameter int COUNT_BITS    = sevuf_pkg::DEF_COUNT_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sevuf_pkg::t_in_item                 i_in_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [sevuf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sevuf_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire sevuf_pkg::t_dp_cmd                  i_cmd,
    output sevuf_pkg::t_dp_sts                       o_sts,
    output logic                                     o_res_valid,
    input  wire logic                                i_res_ready,
    output sevuf_pkg::t_out_item                     o_res_data
);
    import sevuf_pkg::*;

    localparam int IDX_W = $clog2(SPECIES_SLOTS);

    typedef struct packed {
        logic [COUNT_BITS-1:0] occ;
        logic [COUNT_BITS-1:0] strong_hits;
        logic [COUNT_BITS-1:0] uniq;
        logic [SCORE_W-1:0]    best;
    } t_entry;

    function automatic logic [IDX_W-1:0] to_addr(input logic [SP_W-1:0] sp);
        logic [SP_W+IDX_W-1:0] ext;
        ext = {{IDX_W{1'b0}}, sp};
        return ext[IDX_W-1:0];
    endfunction

    function automatic logic in_range(input logic [SP_W-1:0] sp);
        return 32'(sp) < 32'(SPECIES_SLOTS);
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

    function automatic logic [OUT_CNT_W-1:0] clip32(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+OUT_CNT_W-1:0] ext;
        ext = {{OUT_CNT_W{1'b0}}, c};
        return (|ext[COUNT_BITS+OUT_CNT_W-1:OUT_CNT_W]) ? {OUT_CNT_W{1'b1}}
                                                        : ext[OUT_CNT_W-1:0];
    endfunction

    function automatic logic meets_min(input logic [COUNT_BITS-1:0] c,
                                       input logic [CFG_W-1:0] m);
        logic [COUNT_BITS+CFG_W-1:0] a;
        logic [COUNT_BITS+CFG_W-1:0] b;
        a = {{CFG_W{1'b0}}, c};
        b = {{COUNT_BITS{1'b0}}, m};
        return a >= b;
    endfunction

    // config registers
    logic [CFG_W-1:0] r_min_strong_score;
    logic [CFG_W-1:0] r_min_strong_reads;
    logic [CFG_W-1:0] r_min_unique_reads;
    logic [CFG_W-1:0] r_tie_ratio;

    // latched item
    logic               r_op;
    logic [SP_W-1:0]    r_sp;
    logic [SCORE_W-1:0] r_score;
    logic               r_first;
    logic               r_last;

    // pending top of the current read
    logic               r_pending;
    logic [SP_W-1:0]    r_pend_sp;
    logic [SCORE_W-1:0] r_pend_score;
    logic [2*SCORE_W-1:0] r_tie_prod;

    logic [IDX_W-1:0] r_clr_idx;
    t_entry           mem [SPECIES_SLOTS];
    t_entry           r_rd_data;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    t_entry           credit_entry;
    t_entry           main_entry;
    logic             unique_top;
    logic             sp_ok;
    logic             pend_ok;
    t_out_item        dec_item;
    logic             r_out_valid;
    t_out_item        r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_strong_score <= RST_MIN_STRONG_SCORE;
            r_min_strong_reads <= RST_MIN_STRONG_READS;
            r_min_unique_reads <= RST_MIN_UNIQUE_READS;
            r_tie_ratio        <= RST_TIE_RATIO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_STRONG_SCORE: r_min_strong_score <= i_cfg_data;
                CFG_MIN_STRONG_READS: r_min_strong_reads <= i_cfg_data;
                CFG_MIN_UNIQUE_READS: r_min_unique_reads <= i_cfg_data;
                CFG_TIE_RATIO:        r_tie_ratio        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op    <= i_in_data.opcode;
            r_sp    <= i_in_data.species_index;
            r_score <= i_in_data.hit_score;
            r_first <= i_in_data.first_of_read;
            r_last  <= i_in_data.last_of_read;
        end
        // top times ratio, settled well before a runner-up is compared
        r_tie_prod <= r_pend_score * r_tie_ratio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 1'b0;
            r_pend_sp    <= '0;
            r_pend_score <= '0;
        end else if (i_cmd.wr_credit) begin
            r_pending <= 1'b0;
        end else if (i_cmd.wr_main && r_first) begin
            r_pending    <= !r_last;
            r_pend_sp    <= r_sp;
            r_pend_score <= r_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_idx <= r_clr_idx + IDX_W'(1);
        end
    end

    assign sp_ok      = in_range(r_sp);
    assign pend_ok    = in_range(r_pend_sp);
    assign unique_top = {1'b0, r_score, 15'd0} < r_tie_prod;

    always_comb begin
        credit_entry      = r_rd_data;
        credit_entry.uniq = sat_inc(r_rd_data.uniq);

        main_entry     = r_rd_data;
        main_entry.occ = sat_inc(r_rd_data.occ);
        if (r_score > r_rd_data.best) begin
            main_entry.best = r_score;
        end
        if (r_score >= r_min_strong_score) begin
            main_entry.strong_hits = sat_inc(r_rd_data.strong_hits);
        end
        // only candidate of its read
        if (r_first && r_last) begin
            main_entry.uniq = sat_inc(r_rd_data.uniq);
        end
    end

    assign rd_en   = i_cmd.rd_pend || i_cmd.rd_main;
    assign rd_addr = i_cmd.rd_pend ? to_addr(r_pend_sp) : to_addr(r_sp);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = to_addr(r_sp);
        wr_data = main_entry;
        priority if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
            wr_data = '0;
        end else if (i_cmd.wr_credit) begin
            wr_en   = pend_ok && unique_top;
            wr_addr = to_addr(r_pend_sp);
            wr_data = credit_entry;
        end else if (i_cmd.wr_main) begin
            wr_en   = sp_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        dec_item = '0;
        if (sp_ok) begin
            dec_item.present          = |r_rd_data.occ;
            dec_item.pass_evidence    = meets_min(r_rd_data.strong_hits, r_min_strong_reads);
            dec_item.pass_unique      = meets_min(r_rd_data.uniq, r_min_unique_reads);
            dec_item.keep             = dec_item.present &&
                                        (dec_item.pass_evidence || dec_item.pass_unique);
            dec_item.occurrence_count = clip32(r_rd_data.occ);
            dec_item.strong_count     = clip32(r_rd_data.strong_hits);
            dec_item.unique_count     = clip32(r_rd_data.uniq);
            dec_item.best_score       = r_rd_data.best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= dec_item;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_data  = r_out_data;

    assign o_sts.op_decide = (r_op == OP_DECIDE);
    assign o_sts.first     = r_first;
    assign o_sts.pending   = r_pending;
    assign o_sts.out_free  = !r_out_valid || i_res_ready;
    assign o_sts.clr_done  = (r_clr_idx == IDX_W'(SPECIES_SLOTS - 1));

    a_credit_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_credit |-> r_pending)
        else $error("credit write without a pending top");

    a_credit_drops_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_credit |=> !r_pending)
        else $error("pending top survived its runner-up");

    a_result_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.load_out))
        else $error("result register filled without a load");

endmodule

`default_nettype wire

@@ rtl/sevuf_ctrl.sv @@
// sequencing of table clear, read-modify-write and decide result
`default_nettype none

module sevuf_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sevuf_pkg::t_dp_sts  i_sts,
    output sevuf_pkg::t_dp_cmd       o_cmd
);
    import sevuf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_WR_CREDIT,
        ST_RD_MAIN,
        ST_WR_MAIN,
        ST_DEC_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   credit_path;

    // runner-up of a pending top: settle the top's credit first
    assign credit_path = !i_sts.op_decide && !i_sts.first && i_sts.pending;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (credit_path) begin
                    o_cmd.rd_pend = 1'b1;
                    n_state       = ST_WR_CREDIT;
                end else begin
                    o_cmd.rd_main = 1'b1;
                    n_state       = i_sts.op_decide ? ST_DEC_OUT : ST_WR_MAIN;
                end
            end
            ST_WR_CREDIT: begin
                o_cmd.wr_credit = 1'b1;
                n_state         = ST_RD_MAIN;
            end
            ST_RD_MAIN: begin
                o_cmd.rd_main = 1'b1;
                n_state       = ST_WR_MAIN;
            end
            ST_WR_MAIN: begin
                o_cmd.wr_main = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_DEC_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    a_credit_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR_CREDIT) |-> ($past(r_state) == ST_ISSUE))
        else $error("credit write not preceded by its read");

endmodule

`default_nettype wire

@@ rtl/species_evidence_uniqueness_filter.sv @@
// top level of the species evidence and uniqueness filter
`default_nettype none

// Per-species evidence table fed by a stream of read candidates, best first.
// An accumulate transaction (opcode 0) bumps its species' occurrence count,
// its strong-hit count when the score reaches min_strong_score, and its best
// score; a read's top candidate is held pending until its runner-up shows up,
// and gets a unique-top credit when it is alone in its read or when
// runner_up * 32768 < top * tie_ratio. A decide transaction (opcode 1)
// returns one species' counters (clipped to 32 bits) and its keep verdict.
// Counters saturate at 2^COUNT_BITS - 1; species indexes at or beyond
// SPECIES_SLOTS touch no entry and decide to an all-zero result.
// Timing: one transaction at a time, set by read-modify-write through the
// single table memory (registered read, then write). Accumulate reads and
// then writes its entry; the runner-up that resolves a pending top does two
// read-modify-writes, the top's credit first; decide reads its entry and
// waits only while the previous result still waits in the output register. After reset the
// table is zeroed by a clearing pass over every SPECIES_SLOTS entry, during which
// no input is taken; configuration writes are taken at any time (ready is
// tied high) and must only happen while the block is idle.
module species_evidence_uniqueness_filter #(
    parameter int SPECIES_SLOTS = sevuf_pkg::DEF_SPECIES_SLOTS,
    parameter int COUNT_BITS    = sevuf_pkg::DEF_COUNT_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sevuf_in_if.sink    i_in,
    sevuf_out_if.source o_res,
    sevuf_cfg_if.sink   i_cfg
);
    import sevuf_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    // register writes never stall
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    // state machine: clear pass, item sequencing, result hand-off
    sevuf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // table memory, pending top, config registers, result register
    sevuf_datapath #(
        .SPECIES_SLOTS (SPECIES_SLOTS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res_data  (o_res.data)
    );

endmodule

`default_nettype wire

@@ bench/tb_sevuf_sb_pkg.sv @@
// scoreboard class that predicts species evidence verdicts and checks them
package tb_sevuf_sb_pkg;
    import sevuf_pkg::*;

    localparam int TABLE_DEPTH = DEF_SPECIES_SLOTS;
    localparam int CNT_W       = DEF_COUNT_BITS;

    class evidence_tracker;
        bit [CNT_W-1:0]   occ_cnt    [TABLE_DEPTH];
        bit [CNT_W-1:0]   strong_cnt [TABLE_DEPTH];
        bit [CNT_W-1:0]   uniq_cnt   [TABLE_DEPTH];
        bit [SCORE_W-1:0] best_seen  [TABLE_DEPTH];

        // top candidate waiting for its runner-up
        bit               top_held;
        bit [SP_W-1:0]    held_species;
        bit [SCORE_W-1:0] held_score;

        logic [CFG_W-1:0] strong_floor;
        logic [CFG_W-1:0] strong_reads_min;
        logic [CFG_W-1:0] unique_reads_min;
        logic [CFG_W-1:0] tie_ratio;

        t_out_item verdict_queue[$];
        int        errors;

        function new();
            strong_floor     = RST_MIN_STRONG_SCORE;
            strong_reads_min = RST_MIN_STRONG_READS;
            unique_reads_min = RST_MIN_UNIQUE_READS;
            tie_ratio        = RST_TIE_RATIO;
            top_held         = 1'b0;
            held_species     = '0;
            held_score       = '0;
            errors           = 0;
        endfunction

        function void write_threshold(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_MIN_STRONG_SCORE: strong_floor     = value;
                CFG_MIN_STRONG_READS: strong_reads_min = value;
                CFG_MIN_UNIQUE_READS: unique_reads_min = value;
                CFG_TIE_RATIO:        tie_ratio        = value;
                default: ;
            endcase
        endfunction

        function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function void tally(bit [SP_W-1:0] sp, bit [SCORE_W-1:0] score);
            occ_cnt[sp] = bump(occ_cnt[sp]);
            if (score > best_seen[sp])
                best_seen[sp] = score;
            if (score >= strong_floor)
                strong_cnt[sp] = bump(strong_cnt[sp]);
        endfunction

        // one accepted input transaction
        function void absorb_item(t_in_item it);
            longint unsigned runner_side;
            longint unsigned top_side;
            t_out_item       v;
            if (it.opcode == OP_ACCUMULATE) begin
                if (it.first_of_read) begin
                    top_held = 1'b0;
                    tally(it.species_index, it.hit_score);
                    if (it.last_of_read) begin
                        uniq_cnt[it.species_index] = bump(uniq_cnt[it.species_index]);
                    end else begin
                        top_held     = 1'b1;
                        held_species = it.species_index;
                        held_score   = it.hit_score;
                    end
                end else begin
                    if (top_held) begin
                        runner_side = longint'(it.hit_score) << 15;
                        top_side    = longint'(held_score) * longint'(tie_ratio);
                        if (runner_side < top_side)
                            uniq_cnt[held_species] = bump(uniq_cnt[held_species]);
                        top_held = 1'b0;
                    end
                    tally(it.species_index, it.hit_score);
                end
            end else begin
                v.occurrence_count = occ_cnt[it.species_index];
                v.strong_count     = strong_cnt[it.species_index];
                v.unique_count     = uniq_cnt[it.species_index];
                v.best_score       = best_seen[it.species_index];
                v.present          = (v.occurrence_count != 0);
                v.pass_evidence    = (v.strong_count >= CNT_W'(strong_reads_min));
                v.pass_unique      = (v.unique_count >= CNT_W'(unique_reads_min));
                v.keep             = v.present && (v.pass_evidence || v.pass_unique);
                verdict_queue = {verdict_queue, v};
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // one accepted result transaction against the oldest prediction
        function void compare_verdict(t_out_item got);
            t_out_item want;
            if (verdict_queue.size() == 0) begin
                errors++;
                $display("%0t: result with none predicted, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = verdict_queue.pop_front();
            check_field("present", want.present, got.present);
            check_field("keep", want.keep, got.keep);
            check_field("pass_evidence", want.pass_evidence, got.pass_evidence);
            check_field("pass_unique", want.pass_unique, got.pass_unique);
            check_field("occurrence_count", want.occurrence_count, got.occurrence_count);
            check_field("strong_count", want.strong_count, got.strong_count);
            check_field("unique_count", want.unique_count, got.unique_count);
            check_field("best_score", want.best_score, got.best_score);
        endfunction

        function int verdicts_owed();
            return verdict_queue.size();
        endfunction
    endclass

endpackage

@@ bench/tb_top.sv @@
// testbench top for the species evidence and uniqueness filter
module tb_top;
    import sevuf_pkg::*;
    import tb_sevuf_sb_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 7;
    // margin for the longest accumulate, the runner-up that resolves a pending top
    localparam int HOLD_OFF       = 8;
    // covers the clearing pass after reset plus stalls
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 205;
    localparam int NUM_PHASES     = 7;

    // receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sevuf_in_if  in_if ();
    sevuf_out_if res_if ();
    sevuf_cfg_if cfg_if ();

    species_evidence_uniqueness_filter uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    evidence_tracker tracker;

    int unsigned rx_tick = 0;
    int          rx_mode;
    bit          tx_gaps;
    int          burst_left;
    int          sent_items;
    int          idle_cycles = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // receiver: its own stall pattern, independent of the sender
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS:   res_if.ready <= 1'b1;
            RX_RANDOM:   res_if.ready <= ($urandom_range(0, 3) != 0);
            default:     res_if.ready <= ((rx_tick % 13) < 8);
        endcase
    end

    // monitors and watchdog; values sampled here are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            tracker.absorb_item(in_if.data);
        if (i_rst_n && res_if.valid && res_if.ready)
            tracker.compare_verdict(res_if.data);
        if (i_rst_n && cfg_if.valid && cfg_if.ready)
            tracker.write_threshold(cfg_if.index, cfg_if.data);

        if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_in_item mk_item(logic op, int sp, int score, bit first, bit last);
        t_in_item it;
        it.opcode        = op;
        it.species_index = sp[SP_W-1:0];
        it.hit_score     = score[SCORE_W-1:0];
        it.first_of_read = first;
        it.last_of_read  = last;
        return it;
    endfunction

    // mostly a small pool so counters build up, sometimes the whole table
    function automatic int pick_species();
        return ($urandom_range(0, 4) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
    endfunction

    // mostly legal q1.15 scores, now and then the full 16 bits
    function automatic int rand_score();
        return ($urandom_range(0, 9) != 0) ? $urandom_range(0, 32768) : $urandom_range(0, 65535);
    endfunction

    // one input transaction; valid stays high when the next one follows at once
    task automatic push(t_in_item it);
        int gap;
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        sent_items++;
        if (tx_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 12);
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(0, 20);
            end
        end
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic wait_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.verdicts_owed() != 0);
    endtask

    // accumulates without a result may still be in flight, so hold off a bit
    task automatic quiesce();
        wait_results();
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    // all four thresholds back to back, valid held high across them
    task automatic write_thresholds(int strong_floor, int strong_reads, int unique_reads,
                                    int ratio);
        logic [CFG_IDX_W-1:0] idx [4];
        int                   val [4];
        idx = '{CFG_MIN_STRONG_SCORE, CFG_MIN_STRONG_READS, CFG_MIN_UNIQUE_READS,
                CFG_TIE_RATIO};
        val = '{strong_floor, strong_reads, unique_reads, ratio};
        for (int k = 0; k < 4; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[k];
            cfg_if.data  <= val[k][CFG_W-1:0];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // one read, mostly best first and now and then left open, with decides mixed in
    task automatic send_read();
        int      n;
        int      pick;
        bit      drop_last;
        int      top;
        int      prev;
        int      score;
        longint  bound;
        pick      = $urandom_range(0, 9);
        n         = (pick < 3) ? 1 : (pick < 7) ? 2 : $urandom_range(3, 4);
        drop_last = ($urandom_range(0, 9) == 0);
        top       = 0;
        prev      = 0;
        for (int k = 0; k < n; k++) begin
            // a decide between candidates must leave the pending top alone
            if ($urandom_range(0, 4) == 0)
                push(mk_item(OP_DECIDE, pick_species(), $urandom_range(0, 65535),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            if (k == 0) begin
                top   = rand_score();
                score = top;
            end else if (k == 1 && $urandom_range(0, 1) == 0) begin
                // runner-up right at the tie boundary, one below, on or above
                bound = (longint'(top) * longint'(tracker.tie_ratio)) >>> 15;
                bound = bound + $urandom_range(0, 2) - 1;
                if (bound < 0)
                    bound = 0;
                if (bound > 65535)
                    bound = 65535;
                score = int'(bound);
            end else begin
                score = $urandom_range(0, prev);
            end
            prev = score;
            push(mk_item(OP_ACCUMULATE, pick_species(), score, k == 0,
                         (k == n - 1) && !drop_last));
        end
    endtask

    // random part of one phase, with one pause that lets the pipeline run dry
    task automatic run_phase(int count);
        int goal;
        int pause_at;
        bit paused;
        goal     = sent_items + count;
        pause_at = sent_items + $urandom_range(20, count - 20);
        paused   = 1'b0;
        while (sent_items < goal) begin
            if (!paused && sent_items >= pause_at) begin
                wait_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                // noise: any opcode, any index, broken read marks
                push(mk_item(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                             $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))));
            end else begin
                send_read();
            end
        end
    endtask

    initial begin
        tracker     = new();
        rx_mode     = RX_RANDOM;
        tx_gaps     = 1'b1;
        burst_left  = 0;
        sent_items  = 0;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_MIN_STRONG_SCORE;
        cfg_if.data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset thresholds; first push waits out the clear
        push(mk_item(OP_DECIDE, 5, 0, 0, 0));                 // untouched species
        push(mk_item(OP_ACCUMULATE, 0, 32768, 1, 1));         // lone candidate, max score
        push(mk_item(OP_ACCUMULATE, 1023, 65535, 1, 0));      // score above 1.0, held
        push(mk_item(OP_ACCUMULATE, 7, 0, 0, 1));             // runner-up zero, top unique
        push(mk_item(OP_ACCUMULATE, 2, 30000, 1, 0));
        push(mk_item(OP_ACCUMULATE, 3, 29700, 0, 1));         // just at the tie, no credit
        push(mk_item(OP_ACCUMULATE, 4, 20000, 1, 0));         // read left open
        push(mk_item(OP_ACCUMULATE, 5, 10000, 1, 1));         // new top drops the open one
        push(mk_item(OP_ACCUMULATE, 6, 22938, 0, 0));         // orphan, exactly strong
        push(mk_item(OP_ACCUMULATE, 8, 22937, 1, 0));         // one below strong
        push(mk_item(OP_DECIDE, 8, 65535, 1, 1));             // decide while top held
        push(mk_item(OP_ACCUMULATE, 9, 22000, 0, 0));         // runner-up, credit to 8
        push(mk_item(OP_ACCUMULATE, 10, 100, 0, 1));          // third candidate
        push(mk_item(OP_DECIDE, 0, 0, 0, 0));
        push(mk_item(OP_DECIDE, 1023, 0, 0, 0));
        push(mk_item(OP_DECIDE, 2, 0, 0, 0));
        push(mk_item(OP_DECIDE, 3, 0, 0, 0));
        push(mk_item(OP_DECIDE, 4, 0, 0, 0));
        push(mk_item(OP_DECIDE, 5, 0, 0, 0));
        push(mk_item(OP_DECIDE, 6, 0, 0, 0));
        push(mk_item(OP_DECIDE, 8, 0, 0, 0));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                quiesce();
                case (phase)
                    // everything strong and passing, no runner-up can make a top unique
                    1: write_thresholds(0, 0, 0, 0);
                    // strictest thresholds, ratio of exactly one
                    2: write_thresholds(32768, 65535, 65535, 32768);
                    default: write_thresholds($urandom_range(16384, 32768),
                                              $urandom_range(0, 6),
                                              $urandom_range(0, 4),
                                              (phase == NUM_PHASES - 1) ?
                                              $urandom_range(0, 32768) :
                                              $urandom_range(26000, 32768));
                endcase
            end
            // phase 3 runs with no idling on either side
            rx_mode = phase % 3;
            tx_gaps = (phase % 4 != 3);
            run_phase(PHASE_ITEMS);
        end

        quiesce();
        if (tracker.errors == 0 && tracker.verdicts_owed() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
